@@ src/ctrc_pkg.sv @@
// ----------------------------------------------------------------------------
// ctrc_pkg - shared types and constants of the coin timing ratio classifier
// event codes, coin classes, register indexes and fixed field widths
// ----------------------------------------------------------------------------
`default_nettype none

package ctrc_pkg;

    localparam int TIME_W        = 16;  // captured timer value
    localparam int RATIO_W       = 16;  // q4.12 threshold
    localparam int FRAC_BITS     = 12;
    localparam int CLASS_W       = 3;
    localparam int CREDIT_W      = 9;
    localparam int CFG_REGS      = 8;
    localparam int CFG_IDX_W     = 3;
    localparam int WRAP_BITS_DEF = 8;

    localparam logic [CREDIT_W-1:0] PRICE_CENTS = 9'd120;

    localparam logic [CREDIT_W-1:0] EURO_CENTS   = 9'd100;
    localparam logic [CREDIT_W-1:0] FIFTY_CENTS  = 9'd50;
    localparam logic [CREDIT_W-1:0] TWENTY_CENTS = 9'd20;
    localparam logic [CREDIT_W-1:0] TEN_CENTS    = 9'd10;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_EURO_MIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EURO_MAX   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIFTY_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIFTY_MAX  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TWENTY_MIN = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TWENTY_MAX = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TEN_MIN    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_TEN_MAX    = 3'd7;

    typedef enum logic [1:0] {
        REQ_FIRST_RISE  = 2'd0,
        REQ_SECOND_RISE = 2'd1,
        REQ_SECOND_FALL = 2'd2,
        REQ_TIMER_WRAP  = 2'd3
    } t_req_kind;

    typedef enum logic [CLASS_W-1:0] {
        CLS_NONE   = 3'd0,
        CLS_TEN    = 3'd1,
        CLS_TWENTY = 3'd2,
        CLS_FIFTY  = 3'd3,
        CLS_EURO   = 3'd4,
        CLS_REJECT = 3'd5
    } t_coin_class;

    typedef logic [CFG_REGS-1:0][RATIO_W-1:0] t_ratio_set;

    // per-stage control carried down the pipeline
    typedef struct packed {
        logic valid;
        logic fall;    // a fall that ends a measurement
    } t_ctl;

endpackage

`default_nettype wire

@@ src/coin_timing_ratio_classifier.sv @@
// ----------------------------------------------------------------------------
// coin_timing_ratio_classifier - coin classifier from sensor edge timing
// measures transit and blocking times, tests their ratio against four
// windows and keeps the credit in whole cents
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   --------  ---------  -------------------  ----------------------------------
//   event     in         i_valid / o_stall    i_req_type, i_capture_time
//   result    out        o_valid / i_stall    o_coin_class, o_credit_cents,
//                                             o_person_paid
//   config    in         i_cfg_wr_en          i_cfg_index, i_cfg_data
//
// one event per cycle while the result is not stalled; each event gives exactly
// one result, held in the output register after the span, scale and grade
// registers (decode/measure in the transfer cycle, then multiply, then classify/credit)
// the eight threshold multipliers are the longest path of the pipeline
// reset is synchronous and clears thresholds, edge times, wrap count and
// credit; no clearing pass, events are taken from the first cycle after reset
// a stalled result holds in the output register; empty stages ahead of it
// keep filling, so o_stall rises only once every stage holds an event
// ----------------------------------------------------------------------------
`default_nettype none

module coin_timing_ratio_classifier
    import ctrc_pkg::*;
#(
    parameter int WRAP_BITS = WRAP_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // event channel
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [TIME_W-1:0]    i_capture_time,
    // result channel
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output logic      [CLASS_W-1:0]   o_coin_class,
    output logic      [CREDIT_W-1:0]  o_credit_cents,
    output logic                      o_person_paid,
    // configuration write port
    input  wire logic                 i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [RATIO_W-1:0]   i_cfg_data
);

    // span of wrap count plus timer, and its product with a q4.12 bound
    localparam int SPAN_W = WRAP_BITS + TIME_W;
    localparam int PROD_W = SPAN_W + RATIO_W;

    t_ratio_set                      ratios;
    t_ctl                            span_ctl;
    t_ctl                            scale_ctl;
    logic [SPAN_W-1:0]               span_b;
    logic [SPAN_W-1:0]               span_a;
    logic                            a_zero;
    logic [PROD_W-1:0]               b_scaled;
    logic [CFG_REGS-1:0][PROD_W-1:0] prod;
    logic                            adv_grade;
    logic                            adv_scale;
    logic                            adv_span;
    logic                            accept;

    // each stage moves when the one after it is empty or moving,
    // so bubbles close up behind a stalled result
    assign adv_grade = !o_valid || !i_stall;
    assign adv_scale = !scale_ctl.valid || adv_grade;
    assign adv_span  = !span_ctl.valid || adv_scale;
    assign o_stall   = !adv_span;
    assign accept    = i_valid && adv_span;

    ctrc_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr_en  (i_cfg_wr_en),
        .i_index  (i_cfg_index),
        .i_data   (i_cfg_data),
        .o_ratios (ratios)
    );

    // event decode, wrap counting, times a and b
    ctrc_span #(
        .WRAP_BITS (WRAP_BITS)
    ) u_span (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_adv          (adv_span),
        .i_req_type     (i_req_type),
        .i_capture_time (i_capture_time),
        .o_ctl          (span_ctl),
        .o_span_b       (span_b),
        .o_span_a       (span_a)
    );

    // cross-multiplication against all eight bounds in parallel
    ctrc_scale #(
        .WRAP_BITS (WRAP_BITS)
    ) u_scale (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv_scale),
        .i_ctl      (span_ctl),
        .i_span_b   (span_b),
        .i_span_a   (span_a),
        .i_ratios   (ratios),
        .o_ctl      (scale_ctl),
        .o_a_zero   (a_zero),
        .o_b_scaled (b_scaled),
        .o_prod     (prod)
    );

    // priority window test, credit update, result register
    ctrc_grade #(
        .WRAP_BITS (WRAP_BITS)
    ) u_grade (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (adv_grade),
        .i_ctl          (scale_ctl),
        .i_a_zero       (a_zero),
        .i_b_scaled     (b_scaled),
        .i_prod         (prod),
        .o_valid        (o_valid),
        .o_coin_class   (o_coin_class),
        .o_credit_cents (o_credit_cents),
        .o_person_paid  (o_person_paid)
    );

    // a paid result always shows the cleared credit
    a_paid_clears : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_person_paid |-> o_credit_cents == '0)
        else $error("paid pulse with credit left");

    // credit never rests at or above the price
    a_credit_below_price : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_credit_cents < PRICE_CENTS)
        else $error("credit at or above price");

    // no payment without a classified coin
    a_paid_needs_coin : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_person_paid |-> o_coin_class != CLS_NONE
                                  && o_coin_class != CLS_REJECT)
        else $error("paid pulse without a coin");

    // an empty first stage always takes an event
    a_no_stall_when_empty : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !span_ctl.valid |-> !o_stall)
        else $error("stall with empty first stage");

endmodule

`default_nettype wire

@@ src/ctrc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// ctrc_cfg_regs - ratio threshold registers
// eight q4.12 window bounds written through a plain write port
// ----------------------------------------------------------------------------
`default_nettype none

module ctrc_cfg_regs
    import ctrc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_index,
    input  wire logic [RATIO_W-1:0]   i_data,
    output t_ratio_set                o_ratios
);

    t_ratio_set r_ratios;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratios <= '0;
        end else if (i_wr_en) begin
            r_ratios[i_index] <= i_data;
        end
    end

    assign o_ratios = r_ratios;

endmodule

`default_nettype wire

@@ src/ctrc_span.sv @@
// ----------------------------------------------------------------------------
// ctrc_span - event decode and interval measurement
// keeps edge times, wrap count and time a; emits times a and b on a fall
// ----------------------------------------------------------------------------
`default_nettype none

module ctrc_span
    import ctrc_pkg::*;
#(
    parameter int WRAP_BITS = WRAP_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_accept,
    input  wire logic                            i_adv,
    input  wire logic [1:0]                      i_req_type,
    input  wire logic [TIME_W-1:0]               i_capture_time,
    output t_ctl                                 o_ctl,
    output logic      [WRAP_BITS+TIME_W-1:0]     o_span_b,
    output logic      [WRAP_BITS+TIME_W-1:0]     o_span_a
);

    localparam int SPAN_W = WRAP_BITS + TIME_W;

    logic [TIME_W-1:0]    r_first_time,  n_first_time;
    logic [TIME_W-1:0]    r_second_time, n_second_time;
    logic [WRAP_BITS-1:0] r_wrap_count,  n_wrap_count;
    logic [SPAN_W-1:0]    r_transit,     n_transit;
    logic                 r_awaiting,    n_awaiting;
    t_ctl                 r_ctl,         n_ctl;
    logic [SPAN_W-1:0]    r_span_b,      n_span_b;
    logic [SPAN_W-1:0]    r_span_a;
    t_req_kind            kind;

    // wraps * 65536 + now - start; modulo 65536 when no wrap was seen
    function automatic logic [SPAN_W-1:0] f_span(
        input logic [TIME_W-1:0]    start,
        input logic [TIME_W-1:0]    now,
        input logic [WRAP_BITS-1:0] wraps
    );
        logic [SPAN_W-1:0] diff;
        diff = {wraps, now} - SPAN_W'(start);
        if (wraps == '0) begin
            return SPAN_W'(diff[TIME_W-1:0]);
        end
        return diff;
    endfunction

    assign kind = t_req_kind'(i_req_type);

    always_comb begin
        n_first_time  = r_first_time;
        n_second_time = r_second_time;
        n_wrap_count  = r_wrap_count;
        n_transit     = r_transit;
        n_awaiting    = r_awaiting;
        n_ctl.valid   = i_accept;
        n_ctl.fall    = 1'b0;
        n_span_b      = f_span(r_second_time, i_capture_time, r_wrap_count);
        if (i_accept) begin
            unique case (kind)
                REQ_FIRST_RISE: begin
                    n_first_time = i_capture_time;
                    n_wrap_count = '0;
                end
                REQ_SECOND_RISE: begin
                    if (!r_awaiting) begin
                        n_transit     = f_span(r_first_time, i_capture_time, r_wrap_count);
                        n_second_time = i_capture_time;
                        n_wrap_count  = '0;
                        n_awaiting    = 1'b1;
                    end
                end
                REQ_SECOND_FALL: begin
                    if (r_awaiting) begin
                        n_awaiting = 1'b0;
                        n_ctl.fall = 1'b1;
                    end
                end
                REQ_TIMER_WRAP: begin
                    // saturate at all ones
                    if (r_wrap_count != '1) begin
                        n_wrap_count = r_wrap_count + 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_time  <= '0;
            r_second_time <= '0;
            r_wrap_count  <= '0;
            r_transit     <= '0;
            r_awaiting    <= 1'b0;
            r_ctl         <= '0;
        end else begin
            r_first_time  <= n_first_time;
            r_second_time <= n_second_time;
            r_wrap_count  <= n_wrap_count;
            r_transit     <= n_transit;
            r_awaiting    <= n_awaiting;
            if (i_adv) begin
                r_ctl <= n_ctl;
            end
        end
    end

    // time a is read before any update; only a second rise changes it
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_span_b <= n_span_b;
            r_span_a <= r_transit;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_span_b = r_span_b;
    assign o_span_a = r_span_a;

endmodule

`default_nettype wire

@@ src/ctrc_scale.sv @@
// ----------------------------------------------------------------------------
// ctrc_scale - cross-multiplication stage
// multiplies time a by every window bound and scales time b to q4.12
// ----------------------------------------------------------------------------
`default_nettype none

module ctrc_scale
    import ctrc_pkg::*;
#(
    parameter int WRAP_BITS = WRAP_BITS_DEF
) (
    input  wire logic                                                  i_clk,
    input  wire logic                                                  i_rst_n,
    input  wire logic                                                  i_adv,
    input  t_ctl                                                       i_ctl,
    input  wire logic [WRAP_BITS+TIME_W-1:0]                           i_span_b,
    input  wire logic [WRAP_BITS+TIME_W-1:0]                           i_span_a,
    input  t_ratio_set                                                 i_ratios,
    output t_ctl                                                       o_ctl,
    output logic                                                       o_a_zero,
    output logic [WRAP_BITS+TIME_W+RATIO_W-1:0]                        o_b_scaled,
    output logic [CFG_REGS-1:0][WRAP_BITS+TIME_W+RATIO_W-1:0]          o_prod
);

    localparam int SPAN_W = WRAP_BITS + TIME_W;
    localparam int PROD_W = SPAN_W + RATIO_W;

    t_ctl                           r_ctl;
    logic                           r_a_zero;
    logic [PROD_W-1:0]              r_b_scaled;
    logic [CFG_REGS-1:0][PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_adv) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_a_zero   <= (i_span_a == '0);
            r_b_scaled <= PROD_W'({i_span_b, {FRAC_BITS{1'b0}}});
            for (int k = 0; k < CFG_REGS; k++) begin
                r_prod[k] <= PROD_W'(i_ratios[k]) * PROD_W'(i_span_a);
            end
        end
    end

    assign o_ctl      = r_ctl;
    assign o_a_zero   = r_a_zero;
    assign o_b_scaled = r_b_scaled;
    assign o_prod     = r_prod;

endmodule

`default_nettype wire

@@ src/ctrc_grade.sv @@
// ----------------------------------------------------------------------------
// ctrc_grade - window test, credit and result register
// first matching window wins; credit clears with a paid pulse at or above the price
// ----------------------------------------------------------------------------
`default_nettype none

module ctrc_grade
    import ctrc_pkg::*;
#(
    parameter int WRAP_BITS = WRAP_BITS_DEF
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_adv,
    input  t_ctl                                              i_ctl,
    input  wire logic                                         i_a_zero,
    input  wire logic [WRAP_BITS+TIME_W+RATIO_W-1:0]          i_b_scaled,
    input  wire logic [CFG_REGS-1:0][WRAP_BITS+TIME_W+RATIO_W-1:0] i_prod,
    output logic                                              o_valid,
    output logic      [CLASS_W-1:0]                           o_coin_class,
    output logic      [CREDIT_W-1:0]                          o_credit_cents,
    output logic                                              o_person_paid
);

    logic               r_valid;
    t_coin_class        r_class,  n_class;
    logic [CREDIT_W-1:0] r_credit, n_credit;
    logic               r_paid,   n_paid;
    logic [CREDIT_W-1:0] add;
    logic [CREDIT_W-1:0] sum;
    logic               hit_euro, hit_fifty, hit_twenty, hit_ten;

    // open window: min*a < b*4096 < max*a
    assign hit_euro   = (i_b_scaled > i_prod[REG_EURO_MIN])
                     && (i_b_scaled < i_prod[REG_EURO_MAX]);
    assign hit_fifty  = (i_b_scaled > i_prod[REG_FIFTY_MIN])
                     && (i_b_scaled < i_prod[REG_FIFTY_MAX]);
    assign hit_twenty = (i_b_scaled > i_prod[REG_TWENTY_MIN])
                     && (i_b_scaled < i_prod[REG_TWENTY_MAX]);
    assign hit_ten    = (i_b_scaled > i_prod[REG_TEN_MIN])
                     && (i_b_scaled < i_prod[REG_TEN_MAX]);

    always_comb begin
        n_class = CLS_NONE;
        add     = '0;
        if (i_ctl.fall) begin
            if (i_a_zero) begin
                n_class = CLS_REJECT;
            end else if (hit_euro) begin
                n_class = CLS_EURO;
                add     = EURO_CENTS;
            end else if (hit_fifty) begin
                n_class = CLS_FIFTY;
                add     = FIFTY_CENTS;
            end else if (hit_twenty) begin
                n_class = CLS_TWENTY;
                add     = TWENTY_CENTS;
            end else if (hit_ten) begin
                n_class = CLS_TEN;
                add     = TEN_CENTS;
            end else begin
                n_class = CLS_REJECT;
            end
        end
        sum      = r_credit + add;
        n_credit = r_credit;
        n_paid   = 1'b0;
        if (i_ctl.fall) begin
            if (sum >= PRICE_CENTS) begin
                n_credit = '0;
                n_paid   = 1'b1;
            end else begin
                n_credit = sum;
            end
        end
    end

    // credit state doubles as the result's credit field
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_credit <= '0;
        end else if (i_adv) begin
            r_valid <= i_ctl.valid;
            if (i_ctl.valid) begin
                r_credit <= n_credit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_class <= n_class;
            r_paid  <= n_paid;
        end
    end

    assign o_valid        = r_valid;
    assign o_coin_class   = r_class;
    assign o_credit_cents = r_credit;
    assign o_person_paid  = r_paid;

endmodule

`default_nettype wire
